[hw/rtl/svm_pkg.sv]
// ----------------------------------------------------------------------------
// svm_pkg
// Shared types, codes and sizes for the sample voice mixer.
// ----------------------------------------------------------------------------
package svm_pkg;

   localparam int NUM_VOICES   = 8;
   localparam int VOICE_W      = $clog2(NUM_VOICES);
   localparam int COUNT_W      = $clog2(NUM_VOICES + 1);
   localparam int SAMPLE_DEPTH = 16384;
   localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
   localparam int LEN_W        = ADDR_W + 1;
   localparam int ACC_W        = 16 + 9 + VOICE_W + 1;

   // action codes
   localparam logic [2:0] ACT_LOAD   = 3'd0;
   localparam logic [2:0] ACT_PLAY   = 3'd1;
   localparam logic [2:0] ACT_PAUSE  = 3'd2;
   localparam logic [2:0] ACT_RESUME = 3'd3;
   localparam logic [2:0] ACT_STOP   = 3'd4;
   localparam logic [2:0] ACT_TICK   = 3'd5;

   // register indexes
   localparam logic REG_VOLUME = 1'b0;
   localparam logic REG_MUTE   = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic                start;     // latch request word, run non-tick action
      logic                tick_clr;  // clear accumulator
      logic                rd_issue;  // read store for voice at scan index
      logic                mac;       // accumulate sample read last cycle
      logic [VOICE_W-1:0]  vidx;      // voice under scan
      logic                vidx_ok;   // voice at vidx is mixing
      logic                finish;    // build response word
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic [NUM_VOICES-1:0] mixing;  // active and unpaused snapshot
      logic                  is_tick;
   } sts_type;

endpackage

[hw/rtl/sample_voice_mixer_top.sv]
// ----------------------------------------------------------------------------
// sample_voice_mixer_top
// Eight-voice sample player and mixer.
//
//  channel  direction  payload
//  req_     in         tuser: action; tdata: address, sample_in, length, looping, voice
//  rsp_     out        tdata: mixed_sample, granted_voice, play_refused, active_mask
//  csr_     in         index 0 volume, 1 mute
//
// A tick scans the voices one a cycle through the sample store read port.
// Reset is synchronous; the store needs no clearing. A new word is taken only
// when the response register is empty or is being read in the same cycle.
// ----------------------------------------------------------------------------
module sample_voice_mixer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // action
   input  logic [55:0] req_tdata,   // address, sample_in, length, looping, voice
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // mixed_sample, granted_voice, play_refused, active_mask
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [8:0]  csr_data
);

   svm_pkg::ctl_type ctl;
   svm_pkg::sts_type sts;
   logic signed [15:0] mixed_sample;
   logic [2:0]         granted_voice;
   logic               play_refused;
   logic [7:0]         active_mask;

   assign csr_ready = 1'b1;

   svm_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .sts(sts), .ctl(ctl)
   );

   svm_dp u_dp (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data),
      .action(req_tuser), .address(req_tdata[13:0]),
      .sample_in(req_tdata[29:14]), .length(req_tdata[44:30]),
      .looping(req_tdata[45]), .voice(req_tdata[48:46]),
      .ctl(ctl), .sts(sts),
      .mixed_sample(mixed_sample), .granted_voice(granted_voice),
      .play_refused(play_refused), .active_mask(active_mask)
   );

   assign rsp_tdata = {4'd0, active_mask, play_refused, granted_voice, mixed_sample};

`ifndef SYNTH
   // no new word while a response is pending and not being taken
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken over pending response");
   // a refused play grants voice zero
   a_refused: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && play_refused |-> granted_voice == 3'd0)
      else $error("refused play with a voice");
`endif

endmodule

[hw/rtl/svm_ram.sv]
// ----------------------------------------------------------------------------
// svm_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module svm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/svm_ctrl.sv]
// ----------------------------------------------------------------------------
// svm_ctrl
// Controller: accepts a request word, scans voices for a tick, hands the
// response word over.
// ----------------------------------------------------------------------------
module svm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  svm_pkg::sts_type sts,
   output svm_pkg::ctl_type ctl
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_LAST = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [svm_pkg::VOICE_W-1:0] idx_ff, idx_in;
   logic                        mac_ff, mac_in;
   logic                        valid_ff, valid_in;
   logic                        accept;

   // accept a new word while idle once the output slot is free or being taken
   assign req_tready = (state_ff == ST_IDLE) && (!valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = valid_ff;

   // next-state logic
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      mac_in   = 1'b0;
      valid_in = valid_ff && !rsp_tready;
      ctl      = '0;
      ctl.vidx = idx_ff;
      ctl.vidx_ok = sts.mixing[idx_ff];
      ctl.mac  = mac_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctl.start    = 1'b1;
               ctl.tick_clr = 1'b1;
               idx_in       = '0;
               state_in     = sts.is_tick ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            ctl.rd_issue = 1'b1;
            mac_in       = 1'b1;
            idx_in       = idx_ff + 1'b1;
            if (idx_ff == svm_pkg::VOICE_W'(svm_pkg::NUM_VOICES - 1)) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            ctl.finish = 1'b1;
            valid_in   = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         mac_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         mac_ff   <= mac_in;
         valid_ff <= valid_in;
      end
   end

endmodule

[hw/rtl/svm_dp.sv]
// ----------------------------------------------------------------------------
// svm_dp
// Datapath: voice table, free stack, sample store, mix accumulator.
// ----------------------------------------------------------------------------
module svm_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic                            csr_index,
   input  logic [8:0]                      csr_data,
   input  logic [2:0]                      action,
   input  logic [svm_pkg::ADDR_W-1:0]      address,
   input  logic signed [15:0]              sample_in,
   input  logic [svm_pkg::LEN_W-1:0]       length,
   input  logic                            looping,
   input  logic [2:0]                      voice,
   input  svm_pkg::ctl_type                ctl,
   output svm_pkg::sts_type                sts,
   output logic signed [15:0]              mixed_sample,
   output logic [2:0]                      granted_voice,
   output logic                            play_refused,
   output logic [7:0]                      active_mask
);

   localparam int NV = svm_pkg::NUM_VOICES;
   localparam int VW = svm_pkg::VOICE_W;
   localparam int AW = svm_pkg::ADDR_W;
   localparam int LW = svm_pkg::LEN_W;

   logic [8:0]          volume_ff;
   logic                mute_ff;
   logic [2:0]          act_ff;
   logic [NV-1:0]       active_ff, paused_ff, loops_ff;
   logic [AW-1:0]       start_ff  [NV];
   logic [LW-1:0]       len_ff    [NV];
   logic [AW-1:0]       offset_ff [NV];
   logic [VW-1:0]       stack_ff  [NV];
   logic [svm_pkg::COUNT_W-1:0] count_ff;
   logic signed [svm_pkg::ACC_W-1:0] acc_ff;
   logic                macok_ff;
   logic signed [15:0]  mix_ff;
   logic [2:0]          grant_ff;
   logic                refused_ff;
   logic [7:0]          mask_ff;
   logic                refused_pend_ff;
   logic [2:0]          grant_pend_ff_v;

   logic                wr_en;
   logic [AW-1:0]       rd_addr;
   logic signed [15:0]  rd_data;
   logic signed [15:0]  load_val;
   logic signed [25:0]  prod;
   logic signed [svm_pkg::ACC_W-1:0] term;
   logic [VW-1:0]       top;
   logic [VW-1:0]       vsel;
   logic                vsel_ok;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff <= 9'd256;
         mute_ff   <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            svm_pkg::REG_VOLUME: volume_ff <= csr_data;
            default:             mute_ff   <= csr_data[0];
         endcase
      end
   end

   // load: divide by eight toward zero
   assign load_val = (sample_in + (sample_in[15] ? 16'sd7 : 16'sd0)) >>> 3;
   assign wr_en    = ctl.start && (action == svm_pkg::ACT_LOAD);
   assign rd_addr  = start_ff[ctl.vidx] + offset_ff[ctl.vidx];

   svm_ram #(.WIDTH(16), .DEPTH(svm_pkg::SAMPLE_DEPTH)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(address),
      .wr_data(load_val),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // mix term: sample times volume over 256, truncated toward zero
   assign prod = rd_data * $signed({1'b0, volume_ff});
   assign term = svm_pkg::ACC_W'((prod + (prod[25] ? 26'sd255 : 26'sd0)) >>> 8);
   assign top  = VW'(count_ff - 1'b1);
   assign vsel = VW'(voice);
   assign vsel_ok = (32'(voice) < NV) && active_ff[vsel];

   // status: mixing voices and kind of the offered word
   always_comb begin
      sts.mixing  = active_ff & ~paused_ff;
      sts.is_tick = (action == svm_pkg::ACT_TICK);
   end

   // voice table, free stack, accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         paused_ff <= '0;
         loops_ff  <= '0;
         count_ff  <= svm_pkg::COUNT_W'(NV);
         act_ff    <= '0;
         macok_ff  <= 1'b0;
         for (int i = 0; i < NV; i++) begin
            stack_ff[i]  <= VW'(i);
            start_ff[i]  <= '0;
            len_ff[i]    <= '0;
            offset_ff[i] <= '0;
         end
      end else begin
         macok_ff <= ctl.rd_issue && ctl.vidx_ok;
         if (ctl.tick_clr) acc_ff <= '0;
         if (ctl.mac && macok_ff && !mute_ff) acc_ff <= acc_ff + term;
         if (ctl.start) begin
            act_ff          <= action;
            refused_pend_ff <= 1'b0;
            grant_pend_ff_v <= '0;
            case (action)
               svm_pkg::ACT_PLAY: begin
                  if (count_ff == '0) begin
                     refused_pend_ff <= 1'b1;
                  end else begin
                     count_ff            <= count_ff - 1'b1;
                     active_ff[stack_ff[top]] <= 1'b1;
                     paused_ff[stack_ff[top]] <= 1'b0;
                     loops_ff[stack_ff[top]]  <= looping;
                     start_ff[stack_ff[top]]  <= address;
                     offset_ff[stack_ff[top]] <= '0;
                     len_ff[stack_ff[top]] <= (length == '0) ? LW'(1) :
                        (length > LW'(svm_pkg::SAMPLE_DEPTH)) ?
                        LW'(svm_pkg::SAMPLE_DEPTH) : length;
                     grant_pend_ff_v <= 3'(stack_ff[top]);
                  end
               end
               svm_pkg::ACT_PAUSE:  if (vsel_ok) paused_ff[vsel] <= 1'b1;
               svm_pkg::ACT_RESUME: if (vsel_ok) paused_ff[vsel] <= 1'b0;
               svm_pkg::ACT_STOP: begin
                  if (vsel_ok) begin
                     active_ff[vsel] <= 1'b0;
                     paused_ff[vsel] <= 1'b0;
                     stack_ff[count_ff[VW-1:0]] <= vsel;
                     count_ff <= count_ff + 1'b1;
                  end
               end
               default: ;
            endcase
         end
         // advance the offset of the voice just read, wrapping or freeing it at its end
         if (ctl.rd_issue && ctl.vidx_ok) begin
            if (LW'(offset_ff[ctl.vidx]) + LW'(1) >= len_ff[ctl.vidx]) begin
               if (loops_ff[ctl.vidx]) begin
                  offset_ff[ctl.vidx] <= '0;
               end else begin
                  active_ff[ctl.vidx] <= 1'b0;
                  paused_ff[ctl.vidx] <= 1'b0;
                  stack_ff[count_ff[VW-1:0]] <= ctl.vidx;
                  count_ff <= count_ff + 1'b1;
               end
            end else begin
               offset_ff[ctl.vidx] <= offset_ff[ctl.vidx] + 1'b1;
            end
         end
         // response word
         if (ctl.finish) begin
            grant_ff   <= grant_pend_ff_v;
            refused_ff <= refused_pend_ff;
            mask_ff    <= 8'(active_ff);
            if (act_ff != svm_pkg::ACT_TICK) mix_ff <= '0;
            else if (acc_ff > 32767) mix_ff <= 16'sh7fff;
            else if (acc_ff < -32768) mix_ff <= -16'sh8000;
            else mix_ff <= 16'(acc_ff);
         end
      end
   end

   assign mixed_sample  = mix_ff;
   assign granted_voice = grant_ff;
   assign play_refused  = refused_ff;
   assign active_mask   = mask_ff;

endmodule
